### rtl/sfr_pkg.sv
// Shared types, constants and the CRC-16/Modbus byte update for the serial frame receiver.
// No dependencies; every other file in rtl/ imports this package.
package sfr_pkg;

	localparam int MAX_PAYLOAD = 64;
	localparam int LEN_W       = 7;
	localparam int IDX_W       = 6;
	localparam int IDLE_W      = 17;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int TDATA_W     = 56;

	localparam logic [15:0]       CRC_POLY = 16'hA001;
	localparam logic [15:0]       CRC_INIT = 16'hFFFF;
	localparam logic [IDLE_W-1:0] IDLE_MAX = '1;
	localparam logic [LEN_W-1:0]  MAX_LEN  = LEN_W'(MAX_PAYLOAD);

	typedef enum logic [3:0] {
		PH_P1   = 4'd0,
		PH_P2   = 4'd1,
		PH_VER  = 4'd2,
		PH_SRC  = 4'd3,
		PH_DST  = 4'd4,
		PH_TYPE = 4'd5,
		PH_SEQ  = 4'd6,
		PH_LEN  = 4'd7,
		PH_PAY  = 4'd8,
		PH_CRCL = 4'd9,
		PH_CRCH = 4'd10
	} phase_t;

	typedef enum logic [2:0] {
		ST_PAYLOAD  = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_BAD_VER  = 3'd2,
		ST_FOREIGN  = 3'd3,
		ST_TOO_LONG = 3'd4,
		ST_CRC_ERR  = 3'd5,
		ST_TIMEOUT  = 3'd6
	} rx_status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NODE      = 3'd0,
		CFG_BROADCAST = 3'd1,
		CFG_PRE_FIRST = 3'd2,
		CFG_PRE_SECND = 3'd3,
		CFG_VERSION   = 3'd4,
		CFG_TIMEOUT   = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CTL_IDLE,
		CTL_EXEC,
		CTL_READ,
		CTL_LOAD
	} ctl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;  // take the accepted item into the input register
		logic commit;   // apply the item's effect to the frame state
		logic rep_load; // move one replayed payload byte into the output register
	} sfr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic single;   // the held item gives exactly one result
		logic replay;   // the held item completes a good frame with payload
		logic rep_last; // the replay counter points at the final payload byte
		logic out_free; // the output register can take a result this cycle
	} sfr_status_t;

	// One byte through the reflected CRC-16/Modbus, one bit per step.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

### rtl/sfr_ctrl.sv
// Controller of the serial frame receiver: sequences item capture, execution and replay.
// Depends on sfr_pkg.
module sfr_ctrl
	import sfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  sfr_status_t st,
	output sfr_cmd_t    cmd
);

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CTL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CTL_IDLE: begin
				if (s_tvalid) begin
					state_d = CTL_EXEC;
				end
			end
			CTL_EXEC: begin
				// A single result has to wait until the output register is free.
				if (!st.single || st.out_free) begin
					state_d = st.replay ? CTL_READ : CTL_IDLE;
				end
			end
			CTL_READ: begin
				state_d = CTL_LOAD;
			end
			CTL_LOAD: begin
				if (st.out_free) begin
					state_d = st.rep_last ? CTL_IDLE : CTL_READ;
				end
			end
			default: begin
				state_d = CTL_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		cmd.capture  = 1'b0;
		cmd.commit   = 1'b0;
		cmd.rep_load = 1'b0;
		unique case (state_q)
			CTL_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
			end
			CTL_EXEC: begin
				cmd.commit = !st.single || st.out_free;
			end
			CTL_READ: begin
			end
			CTL_LOAD: begin
				cmd.rep_load = st.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

### rtl/sfr_datapath.sv
// Datapath of the serial frame receiver: configuration registers, frame parser state,
// CRC update, payload memory and the output register. Depends on sfr_pkg.
module sfr_datapath
	import sfr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_func,
	input  logic [7:0]            in_byte,
	input  sfr_cmd_t              cmd,
	output sfr_status_t           st,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [2:0]            out_status,
	output logic [7:0]            out_source,
	output logic [7:0]            out_dest,
	output logic [7:0]            out_type,
	output logic [7:0]            out_sequence,
	output logic [LEN_W-1:0]      out_length,
	output logic [7:0]            out_pbyte,
	output logic [IDX_W-1:0]      out_index,
	output logic                  out_last
);

	// Configuration registers.
	logic [7:0]  node_q, bcast_q, pre1_q, pre2_q, ver_q;
	logic [15:0] timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q    <= 8'd1;
			bcast_q   <= 8'd255;
			pre1_q    <= 8'h55;
			pre2_q    <= 8'hAA;
			ver_q     <= 8'd1;
			timeout_q <= 16'd50;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NODE:      node_q    <= cfg_data[7:0];
				CFG_BROADCAST: bcast_q   <= cfg_data[7:0];
				CFG_PRE_FIRST: pre1_q    <= cfg_data[7:0];
				CFG_PRE_SECND: pre2_q    <= cfg_data[7:0];
				CFG_VERSION:   ver_q     <= cfg_data[7:0];
				CFG_TIMEOUT:   timeout_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Input register.
	logic       func_q;
	logic [7:0] rx_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= in_func;
			rx_q   <= in_byte;
		end
	end

	// Frame state.
	phase_t            phase_q, n_phase;
	logic [7:0]        src_q, dst_q, type_q, seq_q, crcl_q;
	logic [7:0]        n_src, n_dst, n_type, n_seq, n_crcl;
	logic [LEN_W-1:0]  len_q, n_len, cnt_q, n_cnt;
	logic [15:0]       crc_q, n_crc, crc_in, crc_upd;
	logic [IDLE_W-1:0] idle_q, n_idle, idle_inc;

	logic       single, single_hdr, replay, restart, mem_we;
	rx_status_t single_status;

	assign crc_in  = (phase_q == PH_VER) ? CRC_INIT : crc_q;
	assign crc_upd = crc16_byte(crc_in, rx_q);
	assign idle_inc = (idle_q == IDLE_MAX) ? idle_q : idle_q + IDLE_W'(1);

	always_comb begin
		n_phase       = phase_q;
		n_src         = src_q;
		n_dst         = dst_q;
		n_type        = type_q;
		n_seq         = seq_q;
		n_len         = len_q;
		n_cnt         = cnt_q;
		n_crc         = crc_q;
		n_crcl        = crcl_q;
		n_idle        = idle_q;
		single        = 1'b0;
		single_hdr    = 1'b0;
		single_status = ST_TIMEOUT;
		replay        = 1'b0;
		restart       = 1'b0;
		mem_we        = 1'b0;
		if (func_q) begin
			n_idle = idle_inc;
			if (idle_inc > {1'b0, timeout_q}) begin
				restart = 1'b1;
				single  = (phase_q != PH_P1);
			end
		end else begin
			n_idle = '0;
			unique case (phase_q)
				PH_P1: begin
					if (rx_q == pre1_q) begin
						n_phase = PH_P2;
					end
				end
				PH_P2: begin
					n_phase = (rx_q == pre2_q) ? PH_VER : PH_P1;
				end
				PH_VER: begin
					if (rx_q != ver_q) begin
						single        = 1'b1;
						single_status = ST_BAD_VER;
						restart       = 1'b1;
					end else begin
						n_crc   = crc_upd;
						n_phase = PH_SRC;
					end
				end
				PH_SRC: begin
					n_src   = rx_q;
					n_crc   = crc_upd;
					n_phase = PH_DST;
				end
				PH_DST: begin
					n_dst   = rx_q;
					n_crc   = crc_upd;
					n_phase = PH_TYPE;
				end
				PH_TYPE: begin
					n_type  = rx_q;
					n_crc   = crc_upd;
					n_phase = PH_SEQ;
				end
				PH_SEQ: begin
					n_seq   = rx_q;
					n_crc   = crc_upd;
					n_phase = PH_LEN;
				end
				PH_LEN: begin
					if (rx_q > {1'b0, MAX_LEN}) begin
						single        = 1'b1;
						single_status = ST_TOO_LONG;
						restart       = 1'b1;
					end else begin
						n_len   = rx_q[LEN_W-1:0];
						n_cnt   = '0;
						n_crc   = crc_upd;
						n_phase = (rx_q == 8'd0) ? PH_CRCL : PH_PAY;
					end
				end
				PH_PAY: begin
					mem_we = 1'b1;
					n_crc  = crc_upd;
					n_cnt  = cnt_q + LEN_W'(1);
					if (n_cnt >= len_q) begin
						n_phase = PH_CRCL;
					end
				end
				PH_CRCL: begin
					n_crcl  = rx_q;
					n_phase = PH_CRCH;
				end
				PH_CRCH: begin
					restart = 1'b1;
					// The destination is checked before the CRC.
					if (dst_q != node_q && dst_q != bcast_q) begin
						single        = 1'b1;
						single_status = ST_FOREIGN;
					end else if ({rx_q, crcl_q} != crc_q) begin
						single        = 1'b1;
						single_status = ST_CRC_ERR;
					end else if (len_q == '0) begin
						single        = 1'b1;
						single_hdr    = 1'b1;
						single_status = ST_EMPTY;
					end else begin
						replay = 1'b1;
					end
				end
				default: begin
					restart = 1'b1;
				end
			endcase
		end
		if (restart) begin
			n_phase = PH_P1;
			n_cnt   = '0;
			n_len   = '0;
			n_crc   = CRC_INIT;
			n_crcl  = '0;
			n_idle  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_P1;
			src_q   <= '0;
			dst_q   <= '0;
			type_q  <= '0;
			seq_q   <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
			crc_q   <= CRC_INIT;
			crcl_q  <= '0;
			idle_q  <= '0;
		end else if (cmd.commit) begin
			phase_q <= n_phase;
			src_q   <= n_src;
			dst_q   <= n_dst;
			type_q  <= n_type;
			seq_q   <= n_seq;
			len_q   <= n_len;
			cnt_q   <= n_cnt;
			crc_q   <= n_crc;
			crcl_q  <= n_crcl;
			idle_q  <= n_idle;
		end
	end

	// Payload memory with a registered read port addressed by the replay counter.
	logic [7:0]       mem [MAX_PAYLOAD];
	logic [7:0]       rd_data_q;
	logic [IDX_W-1:0] rep_k_q;
	logic [LEN_W-1:0] rep_n_q;

	always_ff @(posedge clk) begin
		if (cmd.commit && mem_we) begin
			mem[cnt_q[IDX_W-1:0]] <= rx_q;
		end
		rd_data_q <= mem[rep_k_q];
	end

	// The replay length is kept apart because the frame restart clears the header length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_k_q <= '0;
			rep_n_q <= '0;
		end else if (cmd.commit && replay) begin
			rep_k_q <= '0;
			rep_n_q <= len_q;
		end else if (cmd.rep_load) begin
			rep_k_q <= rep_k_q + IDX_W'(1);
		end
	end

	logic rep_last;
	assign rep_last = ({1'b0, rep_k_q} + LEN_W'(1)) == rep_n_q;

	// Output register.
	logic out_valid_q;
	logic load_single;

	assign load_single = cmd.commit && single;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_single || cmd.rep_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_single) begin
			out_status   <= single_status;
			out_source   <= single_hdr ? src_q : 8'd0;
			out_dest     <= single_hdr ? dst_q : 8'd0;
			out_type     <= single_hdr ? type_q : 8'd0;
			out_sequence <= single_hdr ? seq_q : 8'd0;
			out_length   <= '0;
			out_pbyte    <= '0;
			out_index    <= '0;
			out_last     <= 1'b1;
		end else if (cmd.rep_load) begin
			out_status   <= ST_PAYLOAD;
			out_source   <= src_q;
			out_dest     <= dst_q;
			out_type     <= type_q;
			out_sequence <= seq_q;
			out_length   <= rep_n_q;
			out_pbyte    <= rd_data_q;
			out_index    <= rep_k_q;
			out_last     <= rep_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign st.single   = single;
	assign st.replay   = replay;
	assign st.rep_last = rep_last;
	assign st.out_free = !out_valid_q || out_ready;

endmodule

### rtl/serial_frame_receiver_crc16.sv
// Serial frame receiver with CRC-16/Modbus check. Every input item is first accepted into
// the input register and then executed against the frame state, which may wait on the output.
// A drop or empty-frame result enters the output register from the execute state, once it is free.
// A good frame of N payload bytes is replayed byte by byte, one memory read and one load each.
// Asynchronous active-low reset restores the register defaults and the preamble hunt at once;
// the payload memory needs no clearing, so items are accepted as soon as reset is released.
module serial_frame_receiver_crc16
	import sfr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,  // rx_byte
	input  logic                  s_tuser,  // func
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// source_address, dest_address, message_type, sequence_number, payload_length,
	// payload_byte, byte_index, then zero padding
	output logic [TDATA_W-1:0]    m_tdata,
	output logic [2:0]            m_tuser,  // status
	output logic                  m_tlast
);

	sfr_cmd_t    cmd;
	sfr_status_t st;

	logic [7:0]       o_src, o_dst, o_type, o_seq, o_pbyte;
	logic [LEN_W-1:0] o_len;
	logic [IDX_W-1:0] o_idx;

	sfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	sfr_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_func      (s_tuser),
		.in_byte      (s_tdata),
		.cmd          (cmd),
		.st           (st),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.out_status   (m_tuser),
		.out_source   (o_src),
		.out_dest     (o_dst),
		.out_type     (o_type),
		.out_sequence (o_seq),
		.out_length   (o_len),
		.out_pbyte    (o_pbyte),
		.out_index    (o_idx),
		.out_last     (m_tlast)
	);

	assign m_tdata = {3'b000, o_idx, o_pbyte, o_len, o_seq, o_type, o_dst, o_src};

endmodule
